// ----- rtl/tgr_pkg.sv -----
// Shared types, constants and register map of the touch gesture recognizer.
`default_nettype none

package tgr_pkg;

  // Default width of the tick timers and of the time since the first press.
  localparam int TIMER_BITS = 12;

  // Depth of the queue between the classifying front and the result back end.
  localparam int QUEUE_DEPTH = 4;

  // Widths of the payload and of the configuration port.
  localparam int COORD_W     = 8;
  localparam int GESTURE_W   = 3;
  localparam int CFG_TICK_W  = 12;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 12;

  // One input item causes at most two results.
  localparam int NUM_SLOTS = 2;
  localparam int COUNT_W   = 2;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_TAP_RADIUS         = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SLIDE_MIN          = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SINGLE_CLICK_TICKS = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_DOUBLE_CLICK_TICKS = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS_TICKS   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_SCAN_TICKS         = 3'd5;

  // Register values after reset.
  localparam logic [COORD_W-1:0]    RST_TAP_RADIUS         = 8'd10;
  localparam logic [COORD_W-1:0]    RST_SLIDE_MIN          = 8'd50;
  localparam logic [CFG_TICK_W-1:0] RST_SINGLE_CLICK_TICKS = 12'd400;
  localparam logic [CFG_TICK_W-1:0] RST_DOUBLE_CLICK_TICKS = 12'd300;
  localparam logic [CFG_TICK_W-1:0] RST_LONG_PRESS_TICKS   = 12'd1200;
  localparam logic [CFG_TICK_W-1:0] RST_SCAN_TICKS         = 12'd20;

  // Gesture phase.
  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_PRESSED  = 2'd1,
    PH_RELEASED = 2'd2,
    PH_LONG     = 2'd3
  } phase_t;

  // Gesture codes as reported.
  typedef enum logic [GESTURE_W-1:0] {
    G_SINGLE = 3'd0,
    G_DOUBLE = 3'd1,
    G_LONG   = 3'd2,
    G_UP     = 3'd3,
    G_DOWN   = 3'd4,
    G_LEFT   = 3'd5,
    G_RIGHT  = 3'd6
  } gesture_t;

  // Report kinds.
  localparam logic RK_POSITION = 1'b0;
  localparam logic RK_GESTURE  = 1'b1;

  // One result item.
  typedef struct packed {
    logic                 report_kind;
    logic [GESTURE_W-1:0] gesture;
    logic [COORD_W-1:0]   out_x;
    logic [COORD_W-1:0]   out_y;
    logic                 out_pressed;
  } result_t;

  // All results caused by one input item, oldest in slot 0.
  typedef struct packed {
    logic [COUNT_W-1:0]          count;
    result_t [NUM_SLOTS-1:0]     res;
  } bundle_t;

endpackage

`default_nettype wire

// ----- rtl/tgr_front.sv -----
// Front end: holds configuration and gesture state, classifies each item into results.
`default_nettype none

module tgr_front #(
  parameter int TIMER_BITS = tgr_pkg::TIMER_BITS
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                accept,
  input  wire logic                                kind,
  input  wire logic                                pressed,
  input  wire logic [tgr_pkg::COORD_W-1:0]         pos_x,
  input  wire logic [tgr_pkg::COORD_W-1:0]         pos_y,
  input  wire logic                                cfg_write,
  input  wire logic [tgr_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [tgr_pkg::CFG_DATA_W-1:0]      cfg_data,
  output tgr_pkg::bundle_t                         bundle,
  output logic                                     bundle_valid
);

  localparam int CW = (TIMER_BITS > tgr_pkg::CFG_TICK_W) ? TIMER_BITS : tgr_pkg::CFG_TICK_W;
  localparam logic [TIMER_BITS-1:0] TMAX = '1;

  // Saturate a register value to the timer width.
  function automatic logic [TIMER_BITS-1:0] load_timer(
    input logic [tgr_pkg::CFG_TICK_W-1:0] v
  );
    logic [CW-1:0] ve;
    logic [CW-1:0] me;
    ve = CW'(v);
    me = CW'(TMAX);
    if (ve > me) begin
      load_timer = TMAX;
    end else begin
      load_timer = TIMER_BITS'(ve);
    end
  endfunction

  function automatic logic [tgr_pkg::COORD_W-1:0] absdiff(
    input logic [tgr_pkg::COORD_W-1:0] a,
    input logic [tgr_pkg::COORD_W-1:0] b
  );
    absdiff = (a > b) ? (a - b) : (b - a);
  endfunction

  // Configuration registers.
  logic [tgr_pkg::COORD_W-1:0]    tap_radius;
  logic [tgr_pkg::COORD_W-1:0]    slide_min;
  logic [tgr_pkg::CFG_TICK_W-1:0] single_click_ticks;
  logic [tgr_pkg::CFG_TICK_W-1:0] double_click_ticks;
  logic [tgr_pkg::CFG_TICK_W-1:0] long_press_ticks;
  logic [tgr_pkg::CFG_TICK_W-1:0] scan_ticks;

  // Gesture state.
  tgr_pkg::phase_t                phase, phase_next;
  logic [tgr_pkg::COORD_W-1:0]    first_x, first_x_next;
  logic [tgr_pkg::COORD_W-1:0]    first_y, first_y_next;
  logic [tgr_pkg::COORD_W-1:0]    held_x, held_x_next;
  logic [tgr_pkg::COORD_W-1:0]    held_y, held_y_next;
  logic [TIMER_BITS-1:0]          since_press, since_press_next;
  logic [TIMER_BITS-1:0]          long_count, long_count_next;
  logic [TIMER_BITS-1:0]          click_count, click_count_next;
  logic [TIMER_BITS-1:0]          scan_count, scan_count_next;

  // Decoded conditions.
  logic [tgr_pkg::COORD_W-1:0] px, py, dx, dy;
  logic [TIMER_BITS-1:0]       since_inc;
  logic near_p, near_h, dbl_ok, long_ok;
  logic f_scan, f_click, f_long;
  logic scan_emit, click_fire, single_emit, long_emit;
  logic slide_down, slide_up, slide_left, slide_right, any_slide;

  // A released sample reports the last pressed point.
  assign px = pressed ? pos_x : held_x;
  assign py = pressed ? pos_y : held_y;
  assign dx = absdiff(first_x, px);
  assign dy = absdiff(first_y, py);

  assign near_p = (dx < tap_radius) && (dy < tap_radius);
  assign near_h = (absdiff(first_x, held_x) < tap_radius) &&
                  (absdiff(first_y, held_y) < tap_radius);

  assign since_inc = (since_press < TMAX) ? (since_press + 1'b1) : since_press;

  assign dbl_ok  = near_p && (CW'(since_press) < CW'(double_click_ticks));
  assign long_ok = near_p && (CW'(since_inc) >= CW'(long_press_ticks));

  // A timer fires on the tick that takes it from one to zero.
  assign f_scan  = (scan_count == TIMER_BITS'(1));
  assign f_click = (click_count == TIMER_BITS'(1));
  assign f_long  = (long_count == TIMER_BITS'(1));

  assign scan_emit   = kind && f_scan && pressed;
  assign click_fire  = kind && f_click && (phase == tgr_pkg::PH_RELEASED);
  assign single_emit = click_fire && !pressed && near_h;
  assign long_emit   = kind && f_long && (phase == tgr_pkg::PH_PRESSED) && pressed && long_ok;

  // Slide direction on release, checked in priority order.
  assign slide_down  = (first_y < py) && (dx < dy) && (dy > slide_min);
  assign slide_up    = (first_y > py) && (dx < dy) && (dy > slide_min);
  assign slide_left  = (first_x > px) && (dx > dy) && (dx > slide_min);
  assign slide_right = (first_x < px) && (dx > dy) && (dx > slide_min);
  assign any_slide   = slide_down || slide_up || slide_left || slide_right;

  // Next state of the gesture machine and its timers.
  always_comb begin
    phase_next       = phase;
    first_x_next     = first_x;
    first_y_next     = first_y;
    held_x_next      = held_x;
    held_y_next      = held_y;
    since_press_next = since_press;
    long_count_next  = long_count;
    click_count_next = click_count;
    scan_count_next  = scan_count;
    if (accept) begin
      if (!kind) begin
        if (pressed) begin
          case (phase)
            tgr_pkg::PH_IDLE: begin
              first_x_next     = px;
              first_y_next     = py;
              held_x_next      = px;
              held_y_next      = py;
              phase_next       = tgr_pkg::PH_PRESSED;
              since_press_next = '0;
              long_count_next  = load_timer(long_press_ticks);
              scan_count_next  = load_timer(scan_ticks);
            end
            tgr_pkg::PH_RELEASED: begin
              if (dbl_ok) begin
                phase_next       = tgr_pkg::PH_IDLE;
                click_count_next = '0;
              end
            end
            default: ;
          endcase
        end else begin
          case (phase)
            tgr_pkg::PH_PRESSED: begin
              long_count_next = '0;
              scan_count_next = '0;
              if (any_slide) begin
                phase_next = tgr_pkg::PH_IDLE;
              end else begin
                phase_next       = tgr_pkg::PH_RELEASED;
                click_count_next = load_timer(single_click_ticks);
              end
            end
            tgr_pkg::PH_LONG: begin
              phase_next      = tgr_pkg::PH_IDLE;
              long_count_next = '0;
              scan_count_next = '0;
            end
            default: ;
          endcase
        end
      end else begin
        since_press_next = since_inc;
        scan_count_next  = (scan_count != '0) ? (scan_count - 1'b1) : scan_count;
        click_count_next = (click_count != '0) ? (click_count - 1'b1) : click_count;
        long_count_next  = (long_count != '0) ? (long_count - 1'b1) : long_count;
        if (scan_emit) begin
          held_x_next     = pos_x;
          held_y_next     = pos_y;
          scan_count_next = load_timer(scan_ticks);
        end
        if (click_fire) begin
          phase_next = tgr_pkg::PH_IDLE;
        end
        if (long_emit) begin
          phase_next = tgr_pkg::PH_LONG;
        end
      end
    end
  end

  // Results of the item: an optional position report, then an optional gesture.
  tgr_pkg::result_t pos_res, ges_res;
  logic             has_pos, has_ges;

  always_comb begin
    pos_res             = '0;
    pos_res.report_kind = tgr_pkg::RK_POSITION;
    pos_res.out_x       = px;
    pos_res.out_y       = py;
    pos_res.out_pressed = pressed;
    has_pos             = !kind || scan_emit;

    ges_res             = '0;
    ges_res.report_kind = tgr_pkg::RK_GESTURE;
    has_ges             = 1'b0;
    if (!kind) begin
      if (pressed && (phase == tgr_pkg::PH_RELEASED) && dbl_ok) begin
        has_ges         = 1'b1;
        ges_res.gesture = tgr_pkg::G_DOUBLE;
      end else if (!pressed && (phase == tgr_pkg::PH_PRESSED) && any_slide) begin
        has_ges = 1'b1;
        if (slide_down) begin
          ges_res.gesture = tgr_pkg::G_DOWN;
        end else if (slide_up) begin
          ges_res.gesture = tgr_pkg::G_UP;
        end else if (slide_left) begin
          ges_res.gesture = tgr_pkg::G_LEFT;
        end else begin
          ges_res.gesture = tgr_pkg::G_RIGHT;
        end
      end
    end else begin
      if (single_emit) begin
        has_ges         = 1'b1;
        ges_res.gesture = tgr_pkg::G_SINGLE;
      end else if (long_emit) begin
        has_ges         = 1'b1;
        ges_res.gesture = tgr_pkg::G_LONG;
      end
    end

    bundle = '0;
    if (has_pos) begin
      bundle.res[0] = pos_res;
      bundle.res[1] = ges_res;
      bundle.count  = has_ges ? tgr_pkg::COUNT_W'(2) : tgr_pkg::COUNT_W'(1);
    end else begin
      bundle.res[0] = ges_res;
      bundle.res[1] = ges_res;
      bundle.count  = has_ges ? tgr_pkg::COUNT_W'(1) : tgr_pkg::COUNT_W'(0);
    end
    bundle_valid = accept && (has_pos || has_ges);
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      tap_radius         <= tgr_pkg::RST_TAP_RADIUS;
      slide_min          <= tgr_pkg::RST_SLIDE_MIN;
      single_click_ticks <= tgr_pkg::RST_SINGLE_CLICK_TICKS;
      double_click_ticks <= tgr_pkg::RST_DOUBLE_CLICK_TICKS;
      long_press_ticks   <= tgr_pkg::RST_LONG_PRESS_TICKS;
      scan_ticks         <= tgr_pkg::RST_SCAN_TICKS;
    end else if (cfg_write) begin
      case (cfg_index)
        tgr_pkg::REG_TAP_RADIUS:         tap_radius         <= cfg_data[tgr_pkg::COORD_W-1:0];
        tgr_pkg::REG_SLIDE_MIN:          slide_min          <= cfg_data[tgr_pkg::COORD_W-1:0];
        tgr_pkg::REG_SINGLE_CLICK_TICKS: single_click_ticks <= cfg_data;
        tgr_pkg::REG_DOUBLE_CLICK_TICKS: double_click_ticks <= cfg_data;
        tgr_pkg::REG_LONG_PRESS_TICKS:   long_press_ticks   <= cfg_data;
        tgr_pkg::REG_SCAN_TICKS:         scan_ticks         <= cfg_data;
        default: ;
      endcase
    end
  end

  // Gesture state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= tgr_pkg::PH_IDLE;
      first_x     <= '0;
      first_y     <= '0;
      held_x      <= '0;
      held_y      <= '0;
      since_press <= '0;
      long_count  <= '0;
      click_count <= '0;
      scan_count  <= '0;
    end else begin
      phase       <= phase_next;
      first_x     <= first_x_next;
      first_y     <= first_y_next;
      held_x      <= held_x_next;
      held_y      <= held_y_next;
      since_press <= since_press_next;
      long_count  <= long_count_next;
      click_count <= click_count_next;
      scan_count  <= scan_count_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/tgr_fifo.sv -----
// Short queue of result bundles between the front and the back end.
`default_nettype none

module tgr_fifo #(
  parameter int DEPTH = tgr_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  tgr_pkg::bundle_t       push_data,
  output logic                   full,
  input  wire logic              pull,
  output tgr_pkg::bundle_t       pull_data,
  output logic                   empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  tgr_pkg::bundle_t entries [DEPTH];
  logic [PW-1:0]    wr_ptr, rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push, do_pull;

  assign full      = (count == CW'(DEPTH));
  assign empty     = (count == '0);
  assign do_push   = push && !full;
  assign do_pull   = pull && !empty;
  assign pull_data = entries[rd_ptr];

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : (wr_ptr + 1'b1);
      end
      if (do_pull) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : (rd_ptr + 1'b1);
      end
      if (do_push && !do_pull) begin
        count <= count + 1'b1;
      end else if (do_pull && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/tgr_back.sv -----
// Back end: takes bundles from the queue and hands out their results one at a time.
`default_nettype none

module tgr_back (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              q_empty,
  input  tgr_pkg::bundle_t                       q_data,
  output logic                                   q_pull,
  input  wire logic                              pop,
  output logic                                   empty,
  output logic                                   report_kind,
  output logic [tgr_pkg::GESTURE_W-1:0]          gesture,
  output logic [tgr_pkg::COORD_W-1:0]            out_x,
  output logic [tgr_pkg::COORD_W-1:0]            out_y,
  output logic                                   out_pressed,
  output logic                                   last
);

  tgr_pkg::bundle_t cur;
  logic             have;
  logic             idx;
  logic             is_last;
  logic             taken;
  tgr_pkg::result_t head;

  assign head    = cur.res[idx];
  assign is_last = (cur.count == tgr_pkg::COUNT_W'(tgr_pkg::NUM_SLOTS)) ? idx : 1'b1;
  assign taken   = have && pop;
  assign q_pull  = !q_empty && (!have || (taken && is_last));

  // Result ports come straight from the holding register.
  assign empty       = !have;
  assign report_kind = head.report_kind;
  assign gesture     = head.gesture;
  assign out_x       = head.out_x;
  assign out_y       = head.out_y;
  assign out_pressed = head.out_pressed;
  assign last        = is_last;

  // Bundle holding register.
  always_ff @(posedge clk) begin
    if (q_pull) begin
      cur <= q_data;
    end
  end

  // Slot index and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      have <= 1'b0;
      idx  <= 1'b0;
    end else if (q_pull) begin
      have <= 1'b1;
      idx  <= 1'b0;
    end else if (taken) begin
      if (is_last) begin
        have <= 1'b0;
        idx  <= 1'b0;
      end else begin
        idx <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/touch_gesture_recognizer_core.sv -----
// The first result of an item is registered in the queue and then in the output register
// before it shows on the result ports, when nothing older is waiting in either of them.
// Throughput: one item per cycle while the queue is not full; each item yields zero to
// two results, handed out one per cycle while pop is high, so the bundle queue sets the slack.
// Reset: synchronous and active high; state goes idle, timers stop, registers
// take their default values, and the queue and output register empty at once.
`default_nettype none

module touch_gesture_recognizer_core #(
  parameter int TIMER_BITS  = tgr_pkg::TIMER_BITS,
  parameter int QUEUE_DEPTH = tgr_pkg::QUEUE_DEPTH
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              push,
  output logic                                   full,
  input  wire logic                              kind,
  input  wire logic                              pressed,
  input  wire logic [tgr_pkg::COORD_W-1:0]       pos_x,
  input  wire logic [tgr_pkg::COORD_W-1:0]       pos_y,
  output logic                                   empty,
  input  wire logic                              pop,
  output logic                                   report_kind,
  output logic [tgr_pkg::GESTURE_W-1:0]          gesture,
  output logic [tgr_pkg::COORD_W-1:0]            out_x,
  output logic [tgr_pkg::COORD_W-1:0]            out_y,
  output logic                                   out_pressed,
  output logic                                   last,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [tgr_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [tgr_pkg::CFG_DATA_W-1:0]    cfg_data
);

  tgr_pkg::bundle_t front_bundle, q_data;
  logic             front_valid, q_empty, q_pull, accept;

  // The configuration port never stalls.
  assign cfg_ready = 1'b1;
  assign accept    = push && !full;

  // Front end: state update and classification.
  tgr_front #(
    .TIMER_BITS(TIMER_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .kind         (kind),
    .pressed      (pressed),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .cfg_write    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .bundle       (front_bundle),
    .bundle_valid (front_valid)
  );

  // Queue between the two halves.
  tgr_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (front_valid),
    .push_data (front_bundle),
    .full      (full),
    .pull      (q_pull),
    .pull_data (q_data),
    .empty     (q_empty)
  );

  // Back end: serializes the results of each bundle.
  tgr_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_data      (q_data),
    .q_pull      (q_pull),
    .pop         (pop),
    .empty       (empty),
    .report_kind (report_kind),
    .gesture     (gesture),
    .out_x       (out_x),
    .out_y       (out_y),
    .out_pressed (out_pressed),
    .last        (last)
  );

endmodule

`default_nettype wire

// ----- sim/touch_gesture_recognizer_core_test.sv -----
// Self-checking testbench for the touch gesture recognizer core.
module touch_gesture_recognizer_core_test;
  import tgr_pkg::*;

  localparam int QUIET_LIMIT  = 1000;
  localparam int PHASE_ITEMS  = 50;
  localparam int RANDOM_PHASES = 8;
  localparam int SETTLE_CYCLES = 8;

  // One expected result and its end-of-item flag.
  typedef struct packed {
    result_t res;
    logic    last;
  } report_t;

  // One row of the directed stimulus table.
  typedef struct {
    logic       kind;
    logic       pressed;
    logic [7:0] x;
    logic [7:0] y;
    bit         typed;
    report_t    want;
  } step_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic kind = 1'b0;
  logic pressed = 1'b0;
  logic [COORD_W-1:0] pos_x = '0;
  logic [COORD_W-1:0] pos_y = '0;
  logic empty;
  logic pop = 1'b0;
  logic report_kind;
  logic [GESTURE_W-1:0] gesture;
  logic [COORD_W-1:0] out_x;
  logic [COORD_W-1:0] out_y;
  logic out_pressed;
  logic last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  always #6 clk = ~clk;

  touch_gesture_recognizer_core u_dut (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .kind        (kind),
    .pressed     (pressed),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .empty       (empty),
    .pop         (pop),
    .report_kind (report_kind),
    .gesture     (gesture),
    .out_x       (out_x),
    .out_y       (out_y),
    .out_pressed (out_pressed),
    .last        (last),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // Register copies kept by the gesture tracker.
  logic [7:0]  radius_cfg      = RST_TAP_RADIUS;
  logic [7:0]  slide_cfg       = RST_SLIDE_MIN;
  logic [11:0] click_wait_cfg  = RST_SINGLE_CLICK_TICKS;
  logic [11:0] dbl_window_cfg  = RST_DOUBLE_CLICK_TICKS;
  logic [11:0] long_wait_cfg   = RST_LONG_PRESS_TICKS;
  logic [11:0] scan_period_cfg = RST_SCAN_TICKS;

  // Gesture tracker state.
  phase_t      gest_phase  = PH_IDLE;
  logic [7:0]  anchor_x    = '0;
  logic [7:0]  anchor_y    = '0;
  logic [7:0]  hold_x      = '0;
  logic [7:0]  hold_y      = '0;
  logic [11:0] press_age   = '0;
  logic [11:0] long_timer  = '0;
  logic [11:0] click_timer = '0;
  logic [11:0] scan_timer  = '0;

  report_t   expected_reports[$];
  report_t   head_report;
  step_row_t directed_steps[$];
  int        mismatch_count = 0;
  int        quiet_cycles = 0;
  int        idle_mode = 0;
  int        phase_items = 0;

  function automatic logic [7:0] abs_delta(logic [7:0] a, logic [7:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic bit near_anchor(logic [7:0] x, logic [7:0] y);
    return abs_delta(anchor_x, x) < radius_cfg && abs_delta(anchor_y, y) < radius_cfg;
  endfunction

  // Appends one result; the end-of-item flag is set once the item is done.
  task automatic add_report(logic rk, gesture_t g, logic [7:0] x, logic [7:0] y, logic p);
    report_t r;
    r.res.report_kind = rk;
    r.res.gesture     = g;
    r.res.out_x       = x;
    r.res.out_y       = y;
    r.res.out_pressed = p;
    r.last            = 1'b0;
    expected_reports.push_back(r);
  endtask

  // Works out the results of one accepted item and advances the tracker.
  task automatic track_item(logic k, logic p, logic [7:0] sx, logic [7:0] sy);
    logic [7:0] px, py, dx, dy;
    logic fire_scan, fire_click, fire_long;
    int start;
    report_t r;
    start = expected_reports.size();
    px = p ? sx : hold_x;
    py = p ? sy : hold_y;
    if (!k) begin
      add_report(RK_POSITION, G_SINGLE, px, py, p);
      if (p) begin
        if (gest_phase == PH_IDLE) begin
          anchor_x = px; anchor_y = py; hold_x = px; hold_y = py;
          gest_phase = PH_PRESSED;
          press_age = '0;
          long_timer = long_wait_cfg;
          scan_timer = scan_period_cfg;
        end else if (gest_phase == PH_RELEASED && near_anchor(px, py) &&
                     press_age < dbl_window_cfg) begin
          gest_phase = PH_IDLE;
          click_timer = '0;
          add_report(RK_GESTURE, G_DOUBLE, '0, '0, 1'b0);
        end
      end else if (gest_phase == PH_PRESSED) begin
        dx = abs_delta(anchor_x, px);
        dy = abs_delta(anchor_y, py);
        long_timer = '0;
        scan_timer = '0;
        gest_phase = PH_IDLE;
        if (anchor_y < py && dx < dy && dy > slide_cfg) begin
          add_report(RK_GESTURE, G_DOWN, '0, '0, 1'b0);
        end else if (anchor_y > py && dx < dy && dy > slide_cfg) begin
          add_report(RK_GESTURE, G_UP, '0, '0, 1'b0);
        end else if (anchor_x > px && dx > dy && dx > slide_cfg) begin
          add_report(RK_GESTURE, G_LEFT, '0, '0, 1'b0);
        end else if (anchor_x < px && dx > dy && dx > slide_cfg) begin
          add_report(RK_GESTURE, G_RIGHT, '0, '0, 1'b0);
        end else begin
          gest_phase = PH_RELEASED;
          click_timer = click_wait_cfg;
        end
      end else if (gest_phase == PH_LONG) begin
        gest_phase = PH_IDLE;
        long_timer = '0;
        scan_timer = '0;
      end
    end else begin
      // Tick: age first, then the timers count down; a timer fires on reaching zero.
      if (press_age != '1) press_age++;
      fire_scan  = (scan_timer == 12'd1);
      fire_click = (click_timer == 12'd1);
      fire_long  = (long_timer == 12'd1);
      if (scan_timer != '0) scan_timer--;
      if (click_timer != '0) click_timer--;
      if (long_timer != '0) long_timer--;
      if (fire_scan && p) begin
        add_report(RK_POSITION, G_SINGLE, sx, sy, 1'b1);
        hold_x = sx; hold_y = sy;
        scan_timer = scan_period_cfg;
      end
      if (fire_click && gest_phase == PH_RELEASED) begin
        gest_phase = PH_IDLE;
        if (!p && near_anchor(hold_x, hold_y))
          add_report(RK_GESTURE, G_SINGLE, '0, '0, 1'b0);
      end
      if (fire_long && gest_phase == PH_PRESSED && p && near_anchor(sx, sy) &&
          press_age >= long_wait_cfg) begin
        gest_phase = PH_LONG;
        add_report(RK_GESTURE, G_LONG, '0, '0, 1'b0);
      end
    end
    // Flag the final result of this item.
    if (expected_reports.size() > start) begin
      r = expected_reports.pop_back();
      r.last = 1'b1;
      expected_reports.push_back(r);
    end
  endtask

  function automatic bit sender_idles();
    if (idle_mode == 1) return $urandom_range(0, 99) < 70;
    if (idle_mode == 3) return $urandom_range(0, 99) < 12;
    return 1'b0;
  endfunction

  function automatic bit receiver_stalls();
    if (idle_mode == 2) return $urandom_range(0, 99) < 70;
    if (idle_mode == 3) return $urandom_range(0, 99) < 12;
    return 1'b0;
  endfunction

  // Offers one item and returns at the edge where it is accepted.
  // The push line stays high so that back-to-back items need no toggle.
  task automatic send_item(logic k, logic p, logic [7:0] x, logic [7:0] y);
    while (sender_idles()) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    kind    <= k;
    pressed <= p;
    pos_x   <= x;
    pos_y   <= y;
    @(posedge clk);
    while (full) @(posedge clk);
    phase_items++;
  endtask

  task automatic feed(logic k, logic p, logic [7:0] x, logic [7:0] y);
    send_item(k, p, x, y);
    track_item(k, p, x, y);
  endtask

  // Writes one register; the valid line is lowered by the caller.
  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_TAP_RADIUS:         radius_cfg = data[7:0];
      REG_SLIDE_MIN:          slide_cfg = data[7:0];
      REG_SINGLE_CLICK_TICKS: click_wait_cfg = data;
      REG_DOUBLE_CLICK_TICKS: dbl_window_cfg = data;
      REG_LONG_PRESS_TICKS:   long_wait_cfg = data;
      REG_SCAN_TICKS:         scan_period_cfg = data;
      default: ;
    endcase
  endtask

  // The byte-wide registers get random upper data bits, which must be dropped.
  task automatic program_regs(int radius, int slide, int click, int dbl, int hold, int scan);
    write_reg(REG_TAP_RADIUS, {4'($urandom), 8'(radius)});
    write_reg(REG_SLIDE_MIN, {4'($urandom), 8'(slide)});
    write_reg(REG_SINGLE_CLICK_TICKS, 12'(click));
    write_reg(REG_DOUBLE_CLICK_TICKS, 12'(dbl));
    write_reg(REG_LONG_PRESS_TICKS, 12'(hold));
    write_reg(REG_SCAN_TICKS, 12'(scan));
    cfg_valid <= 1'b0;
  endtask

  // Waits until every expected result is out and any silent tick has drained.
  task automatic settle();
    push <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic int pick_ticks();
    case ($urandom_range(0, 11))
      0: return 0;
      1: return 4095;
      2: return 1;
      default: return $urandom_range(1, 8);
    endcase
  endfunction

  function automatic int pick_byte(int lo, int hi);
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 255;
      default: return $urandom_range(lo, hi);
    endcase
  endfunction

  function automatic logic [7:0] jitter(logic [7:0] c, int span);
    int v;
    v = int'(c) + int'($urandom_range(0, 2 * span)) - span;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  // One touch episode: a press, a hold with ticks, a release, then an optional
  // second press and released ticks. A tenth of the episodes are plain noise.
  task automatic run_episode();
    logic [7:0] bx, by, tx, ty;
    int choice;
    bx = 8'($urandom);
    by = 8'($urandom);
    choice = $urandom_range(0, 9);
    if (choice == 0) begin
      repeat ($urandom_range(1, 4))
        feed(1'($urandom), 1'($urandom), 8'($urandom), 8'($urandom));
    end else begin
      if ($urandom_range(0, 2) == 0) begin
        tx = jitter(bx, 4);
        ty = jitter(by, 4);
      end else begin
        tx = 8'($urandom);
        ty = 8'($urandom);
      end
      feed(1'b0, 1'b1, bx, by);
      repeat ($urandom_range(0, 10)) begin
        case ($urandom_range(0, 15))
          0: feed(1'b0, 1'b1, 8'($urandom), 8'($urandom));
          1: feed(1'b1, 1'b0, 8'($urandom), 8'($urandom));
          2, 3, 4, 5, 6: feed(1'b1, 1'b1, jitter(bx, 3), jitter(by, 3));
          default: feed(1'b1, 1'b1, tx, ty);
        endcase
      end
      feed(1'b0, 1'b0, 8'($urandom), 8'($urandom));
      if (choice <= 3) feed(1'b0, 1'b1, jitter(bx, 6), jitter(by, 6));
      repeat ($urandom_range(0, 10))
        feed(1'b1, $urandom_range(0, 7) == 0, 8'($urandom), 8'($urandom));
    end
  endtask

  function automatic step_row_t plain(logic k, logic p, logic [7:0] x, logic [7:0] y);
    step_row_t s;
    s.kind = k; s.pressed = p; s.x = x; s.y = y;
    s.typed = 1'b0;
    s.want = '0;
    return s;
  endfunction

  // A row whose single position report is written out in full.
  function automatic step_row_t typed(logic k, logic p, logic [7:0] x, logic [7:0] y,
                                      logic [7:0] ox, logic [7:0] oy, logic op);
    step_row_t s;
    s = plain(k, p, x, y);
    s.typed = 1'b1;
    s.want.res.report_kind = RK_POSITION;
    s.want.res.gesture     = G_SINGLE;
    s.want.res.out_x       = ox;
    s.want.res.out_y       = oy;
    s.want.res.out_pressed = op;
    s.want.last            = 1'b1;
    return s;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Result side: random stalls and a field-by-field compare with the oldest expectation.
  always @(posedge clk) begin
    pop <= !receiver_stalls();
    if (!rst && pop && !empty) begin
      if (expected_reports.size() == 0) begin
        $error("unexpected result: report_kind %0d gesture %0d x %0d y %0d",
               report_kind, gesture, out_x, out_y);
        mismatch_count++;
      end else begin
        head_report = expected_reports.pop_front();
        check_field("report_kind", head_report.res.report_kind, report_kind);
        check_field("gesture", head_report.res.gesture, gesture);
        check_field("out_x", head_report.res.out_x, out_x);
        check_field("out_y", head_report.res.out_y, out_y);
        check_field("out_pressed", head_report.res.out_pressed, out_pressed);
        check_field("last", head_report.last, last);
      end
    end
  end

  // Counts cycles in which no handshake completes.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int queued;
    // Short timers so that every gesture shows up within a few items.
    directed_steps = '{
      typed(1'b0, 1'b0, 8'd255, 8'd255, 8'd0, 8'd0, 1'b0),
      typed(1'b0, 1'b1, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1),
      plain(1'b1, 1'b1, 8'd0, 8'd255),
      plain(1'b0, 1'b0, 8'd0, 8'd0),
      typed(1'b0, 1'b1, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1),
      plain(1'b1, 1'b1, 8'd200, 8'd0),
      plain(1'b0, 1'b0, 8'd13, 8'd77),
      plain(1'b0, 1'b1, 8'd100, 8'd100),
      plain(1'b1, 1'b1, 8'd100, 8'd20),
      plain(1'b0, 1'b0, 8'd1, 8'd1),
      plain(1'b0, 1'b1, 8'd100, 8'd20),
      plain(1'b1, 1'b1, 8'd100, 8'd200),
      plain(1'b0, 1'b0, 8'd0, 8'd0),
      plain(1'b0, 1'b1, 8'd50, 8'd50),
      plain(1'b0, 1'b0, 8'd50, 8'd50),
      plain(1'b1, 1'b0, 8'd0, 8'd0),
      plain(1'b1, 1'b0, 8'd0, 8'd0),
      plain(1'b1, 1'b0, 8'd0, 8'd0),
      plain(1'b0, 1'b1, 8'd60, 8'd60),
      plain(1'b0, 1'b0, 8'd60, 8'd60),
      plain(1'b0, 1'b1, 8'd62, 8'd61),
      plain(1'b0, 1'b1, 8'd30, 8'd30),
      plain(1'b0, 1'b1, 8'd128, 8'd128),
      plain(1'b1, 1'b1, 8'd31, 8'd29),
      plain(1'b1, 1'b1, 8'd30, 8'd30),
      plain(1'b1, 1'b1, 8'd30, 8'd31),
      plain(1'b0, 1'b0, 8'd0, 8'd0)
    };

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed part: both sides always ready.
    program_regs(10, 50, 3, 4, 3, 1);
    idle_mode = 0;
    foreach (directed_steps[i]) begin
      send_item(directed_steps[i].kind, directed_steps[i].pressed,
                directed_steps[i].x, directed_steps[i].y);
      queued = expected_reports.size();
      track_item(directed_steps[i].kind, directed_steps[i].pressed,
                 directed_steps[i].x, directed_steps[i].y);
      if (directed_steps[i].typed) begin
        while (expected_reports.size() > queued) void'(expected_reports.pop_back());
        expected_reports.push_back(directed_steps[i].want);
      end
    end

    // Random part: extreme settings first, then random ones, cycling the idle modes.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      case (p)
        0: program_regs(255, 0, 1, 4095, 1, 1);
        1: program_regs(0, 255, 4095, 0, 0, 0);
        default: program_regs(pick_byte(1, 40), pick_byte(10, 120), pick_ticks(),
                              pick_ticks(), pick_ticks(), pick_ticks());
      endcase
      idle_mode = p % 4;
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) run_episode();
    end

    settle();
    if (mismatch_count == 0 && expected_reports.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
